// ----- hw/rtl/csvtok_pkg.sv -----
// Shared types and constants for the CSV field tokenizer.
// Used by csvtok_decode, csvtok_out_buf and csv_field_tokenizer_unit.
// No dependencies.
package csvtok_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int COL_W  = 8;
    localparam int KIND_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CELL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROW  = 2'd2;

    // Special characters
    localparam logic [BYTE_W-1:0] BYTE_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] BYTE_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;

    // Reset value of the column count register
    localparam logic [COL_W-1:0] EXPECTED_COLUMNS_RESET = 8'd8;

    // One output word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] char_value;
        logic [COL_W-1:0]  column;
        logic              row_ok;
        logic              last;
    } result_t;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic             quoting;
        logic             quote_pending;
        logic             cr_pending;
        logic             line_has_content;
        logic [COL_W-1:0] cell_count;
    } parse_state_t;

    // Words produced by one text byte, first in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } decode_out_t;

endpackage

// ----- hw/rtl/csvtok_decode.sv -----
// Combinational decode of one text byte against the current parser state.
// Produces the next state and up to two output words.
// Depends on csvtok_pkg.
module csvtok_decode
    import csvtok_pkg::*;
#(
    parameter int MAX_COLUMNS = 255
)
(
    input  logic [BYTE_W-1:0] text_byte,
    input  logic [COL_W-1:0]  expected_columns,
    input  parse_state_t      state_cur,
    output parse_state_t      state_nxt,
    output decode_out_t       words
);

    localparam logic [COL_W-1:0] MAX_COL = COL_W'(MAX_COLUMNS);

    always_comb
    begin
        result_t      res_a;
        result_t      res_b;
        logic         has_a;
        logic         has_b;
        logic         quoting_eff;
        logic         row_ok_w;
        logic [COL_W:0] count_plus;

        state_nxt   = state_cur;
        res_a       = '0;
        res_b       = '0;
        has_a       = 1'b0;
        has_b       = 1'b0;
        count_plus  = {1'b0, state_cur.cell_count} + {{COL_W{1'b0}}, 1'b1};
        row_ok_w    = (state_cur.cell_count < MAX_COL) &&
                      (count_plus == {1'b0, expected_columns});
        quoting_eff = state_cur.quoting;

        res_a.column = state_cur.cell_count;
        res_b.column = state_cur.cell_count;

        if (text_byte == BYTE_LF)
        begin
            // A newline closes the line: if it has content, end of cell, then end of row.
            if (state_cur.line_has_content)
            begin
                has_a       = 1'b1;
                res_a.kind  = KIND_CELL;
                has_b       = 1'b1;
                res_b.kind  = KIND_ROW;
                res_b.row_ok = row_ok_w;
            end
            state_nxt = '0;
        end
        else if (state_cur.quote_pending && (text_byte == BYTE_QUOTE))
        begin
            // Doubled quote inside quotes gives one quote character.
            state_nxt.quote_pending    = 1'b0;
            state_nxt.line_has_content = 1'b1;
            has_b            = 1'b1;
            res_b.kind       = KIND_CHAR;
            res_b.char_value = BYTE_QUOTE;
        end
        else
        begin
            // A lone pending quote closes quoting.
            if (state_cur.quote_pending)
            begin
                quoting_eff = 1'b0;
            end
            state_nxt.quote_pending = 1'b0;
            state_nxt.quoting       = quoting_eff;

            // A held carriage return not followed by a newline is kept only in quotes.
            if (state_cur.cr_pending)
            begin
                state_nxt.cr_pending       = 1'b0;
                state_nxt.line_has_content = 1'b1;
                if (quoting_eff)
                begin
                    has_a            = 1'b1;
                    res_a.kind       = KIND_CHAR;
                    res_a.char_value = BYTE_CR;
                end
            end

            // The current byte.
            if (text_byte == BYTE_CR)
            begin
                state_nxt.cr_pending = 1'b1;
            end
            else
            begin
                state_nxt.line_has_content = 1'b1;
                if (quoting_eff)
                begin
                    if (text_byte == BYTE_QUOTE)
                    begin
                        state_nxt.quote_pending = 1'b1;
                    end
                    else
                    begin
                        has_b            = 1'b1;
                        res_b.kind       = KIND_CHAR;
                        res_b.char_value = text_byte;
                    end
                end
                else if (text_byte == BYTE_QUOTE)
                begin
                    state_nxt.quoting = 1'b1;
                end
                else if (text_byte == BYTE_COMMA)
                begin
                    has_b      = 1'b1;
                    res_b.kind = KIND_CELL;
                    if (state_cur.cell_count < MAX_COL)
                    begin
                        state_nxt.cell_count = count_plus[COL_W-1:0];
                    end
                end
                else
                begin
                    has_b            = 1'b1;
                    res_b.kind       = KIND_CHAR;
                    res_b.char_value = text_byte;
                end
            end
        end

        // Pack the words in order and mark the final one.
        res_b.last = has_b;
        res_a.last = has_a && !has_b;
        words.count = {1'b0, has_a} + {1'b0, has_b};
        if (has_a)
        begin
            words.first  = res_a;
            words.second = res_b;
        end
        else
        begin
            words.first  = res_b;
            words.second = '0;
        end
    end

endmodule

// ----- hw/rtl/csvtok_out_buf.sv -----
// Two-word output buffer that presents the words of one text byte in order.
// The user must load a new group only when it will be empty after this cycle (can_load); the block does not enforce it.
// Depends on csvtok_pkg.
module csvtok_out_buf
    import csvtok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  decode_out_t words,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     head
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    tail_reg;
    result_t    tail_next;
    logic       pop;

    // A group may load when the buffer drains by the end of this cycle.
    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign out_valid = (cnt_reg != 2'd0);
    assign head      = head_reg;

    // Next buffer contents.
    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (load)
        begin
            cnt_next  = words.count;
            head_next = words.first;
            tail_next = words.second;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = tail_reg;
        end
    end

    // Word count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Word payload.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- hw/rtl/csv_field_tokenizer_unit.sv -----
// Top level of the CSV field tokenizer: input register, parser state, output buffer.
// Depends on csvtok_pkg, csvtok_decode and csvtok_out_buf.
//
// Usage:
//   Input channel in_valid/in_ready carries one raw text byte per word (text_byte).
//   Output channel out_valid/out_ready carries one token per word: kind, char_value,
//   column, row_ok and last. A byte yields zero, one or two words; last marks the
//   final word of a byte.
//   cfg_write_en writes expected_columns; write it only while idle.
//   Path: a byte accepted into the input register is decoded from it once the output
//   buffer can take its words, and its first word is then shown from the output buffer.
//   Throughput: one byte per cycle while each byte yields at most one word and out_ready
//   is high; a byte that yields two words (end of cell and end of row, or a held
//   carriage return and a cell byte) makes the next byte wait in the input register,
//   since the output port moves one word per cycle.
//   Stall: when out_ready is low the output buffer holds up to two words; the
//   byte in the input register then waits and in_ready drops, so no word is lost.
//   Reset: parser state clears to outside quotes with an empty row, buffers empty,
//   expected_columns returns to 8.
module csv_field_tokenizer_unit
    import csvtok_pkg::*;
#(
    parameter int MAX_COLUMNS = 255
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [COL_W-1:0]  expected_columns,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] text_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] kind,
    output logic [BYTE_W-1:0] char_value,
    output logic [COL_W-1:0]  column,
    output logic              row_ok,
    output logic              last
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [COL_W-1:0]  exp_cols_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    decode_out_t       words;
    logic              can_load;
    logic              process;
    result_t           head;

    // The held byte is decoded when the output buffer can take its words.
    assign process       = in_valid_reg && can_load;
    assign in_ready      = !in_valid_reg || process;
    assign in_valid_next = (in_valid && in_ready) || (in_valid_reg && !process);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= text_byte;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_cols_reg <= EXPECTED_COLUMNS_RESET;
        end
        else if (cfg_write_en)
        begin
            exp_cols_reg <= expected_columns;
        end
    end

    // Byte decode.
    csvtok_decode #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_decode (
        .text_byte        (in_byte_reg),
        .expected_columns (exp_cols_reg),
        .state_cur        (state_reg),
        .state_nxt        (state_next),
        .words            (words)
    );

    // Parser state advances once per decoded byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (process)
        begin
            state_reg <= state_next;
        end
    end

    // Output buffer.
    csvtok_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (process),
        .words     (words),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind       = head.kind;
    assign char_value = head.char_value;
    assign column     = head.column;
    assign row_ok     = head.row_ok;
    assign last       = head.last;

endmodule
